[rtl/cvmf_pkg.sv]
// cvmf_pkg: shared constants, mode codes and the coefficient table of the
// colour-vision matrix filter, plus the fixed-point coefficient conversion
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package cvmf_pkg;

  localparam int unsigned COEF_FRAC_BITS_DEF = 16;
  localparam int unsigned MODE_COUNT         = 9;
  localparam int unsigned MODE_W             = 4;
  localparam int unsigned PIX_W              = 8;
  localparam int unsigned DEC_SCALE          = 100000;

  typedef enum logic [MODE_W-1:0] {
    MODE_NORMAL        = 4'd0,
    MODE_PROTANOPIA    = 4'd1,
    MODE_PROTANOMALY   = 4'd2,
    MODE_DEUTERANOPIA  = 4'd3,
    MODE_DEUTERANOMALY = 4'd4,
    MODE_TRITANOPIA    = 4'd5,
    MODE_TRITANOMALY   = 4'd6,
    MODE_ACHROMATOPSIA = 4'd7,
    MODE_ACHROMATOMALY = 4'd8
  } vision_mode_t;

  // matrix entries in units of 1e-5, [mode][output channel][input channel]
  localparam int unsigned MAT_DEC [MODE_COUNT][3][3] = '{
    '{'{100000, 0, 0}, '{0, 100000, 0}, '{0, 0, 100000}},
    '{'{56667, 43333, 0}, '{55833, 44167, 0}, '{0, 24167, 75833}},
    '{'{81667, 18333, 0}, '{33333, 66667, 0}, '{0, 12500, 87500}},
    '{'{62500, 37500, 0}, '{70000, 30000, 0}, '{0, 30000, 70000}},
    '{'{80000, 20000, 0}, '{25833, 74167, 0}, '{0, 14167, 85833}},
    '{'{95000, 5000, 0}, '{0, 43333, 56667}, '{0, 47500, 52500}},
    '{'{96667, 3333, 0}, '{0, 73333, 26667}, '{0, 18333, 81667}},
    '{'{29900, 58700, 11400}, '{29900, 58700, 11400}, '{29900, 58700, 11400}},
    '{'{61800, 32000, 6200}, '{16300, 77500, 6200}, '{16300, 32000, 51600}}
  };

  // decimal entry to fixed point, rounded to nearest with ties upward
  function automatic logic [63:0] fixed_coef(input int unsigned dec,
                                             input int unsigned frac_bits);
    logic [63:0] scaled;
    scaled = 64'(dec) << frac_bits;
    return (scaled + 64'(DEC_SCALE / 2)) / 64'(DEC_SCALE);
  endfunction

endpackage

`default_nettype wire

[rtl/cvmf_coef_sel.sv]
// cvmf_coef_sel: first pipeline stage, picks the matrix for the current mode
// and registers it together with the pixel; uses cvmf_pkg
`timescale 1ns / 1ps
`default_nettype none

module cvmf_coef_sel
  import cvmf_pkg::*;
#(
  parameter int unsigned FRAC_BITS = COEF_FRAC_BITS_DEF,
  localparam int unsigned CW = FRAC_BITS + 1
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             load,
  input  wire logic                             valid_in,
  input  wire logic [PIX_W-1:0]                 red,
  input  wire logic [PIX_W-1:0]                 green,
  input  wire logic [PIX_W-1:0]                 blue,
  input  wire logic [MODE_W-1:0]                mode,
  output logic                                  valid,
  output logic [2:0][PIX_W-1:0]                 px,
  output logic [2:0][2:0][CW-1:0]               coef
);

  logic [CW-1:0]     coef_tbl [MODE_COUNT][3][3];
  logic [MODE_W-1:0] sel;

  // constant table, folded at elaboration
  always_comb begin
    for (int m = 0; m < MODE_COUNT; m++) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          coef_tbl[m][i][j] = CW'(fixed_coef(MAT_DEC[m][i][j], FRAC_BITS));
        end
      end
    end
  end

  // unused codes fall back to the identity matrix
  assign sel = (mode < MODE_W'(MODE_COUNT)) ? mode : MODE_NORMAL;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      px <= {blue, green, red};
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          coef[i][j] <= coef_tbl[sel][i][j];
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/cvmf_mult.sv]
// cvmf_mult: second pipeline stage, the nine coefficient by channel products
// registered in parallel; uses cvmf_pkg
`timescale 1ns / 1ps
`default_nettype none

module cvmf_mult
  import cvmf_pkg::*;
#(
  parameter int unsigned FRAC_BITS = COEF_FRAC_BITS_DEF,
  localparam int unsigned CW = FRAC_BITS + 1,
  localparam int unsigned PW = CW + PIX_W
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   load,
  input  wire logic                   valid_in,
  input  wire logic [2:0][PIX_W-1:0]  px,
  input  wire logic [2:0][2:0][CW-1:0] coef,
  output logic                        valid,
  output logic [2:0][2:0][PW-1:0]     prod
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod[i][j] <= PW'(coef[i][j]) * PW'(px[j]);
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/cvmf_sum_sat.sv]
// cvmf_sum_sat: last pipeline stage, adds each row, drops the fraction and
// clamps at 255 into the output register; uses cvmf_pkg
`timescale 1ns / 1ps
`default_nettype none

module cvmf_sum_sat
  import cvmf_pkg::*;
#(
  parameter int unsigned FRAC_BITS = COEF_FRAC_BITS_DEF,
  localparam int unsigned CW = FRAC_BITS + 1,
  localparam int unsigned PW = CW + PIX_W,
  localparam int unsigned SW = PW + 2
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   load,
  input  wire logic                   valid_in,
  input  wire logic [2:0][2:0][PW-1:0] prod,
  output logic                        valid,
  output logic [PIX_W-1:0]            red,
  output logic [PIX_W-1:0]            green,
  output logic [PIX_W-1:0]            blue
);

  logic [2:0][SW-1:0]    acc;
  logic [2:0][PIX_W-1:0] chan;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = SW'(prod[i][0]) + SW'(prod[i][1]) + SW'(prod[i][2]);
      // integer part is PIX_W + 3 bits wide, anything above 255 clamps
      if (|acc[i][SW-1:FRAC_BITS+PIX_W]) begin
        chan[i] = '1;
      end else begin
        chan[i] = acc[i][FRAC_BITS +: PIX_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      red   <= chan[0];
      green <= chan[1];
      blue  <= chan[2];
    end
  end

endmodule

`default_nettype wire

[rtl/color_vision_matrix_filter.sv]
// color_vision_matrix_filter: top level, mode register and the three-stage
// pipeline; uses cvmf_pkg, cvmf_coef_sel, cvmf_mult and cvmf_sum_sat
//
// Colour-vision simulation filter. Each item is one 8-bit RGB pixel; it is
// multiplied by one of nine fixed 3x3 matrices picked by vision_mode (0 normal,
// 1 protanopia, 2 protanomaly, 3 deuteranopia, 4 deuteranomaly, 5 tritanopia,
// 6 tritanomaly, 7 achromatopsia, 8 achromatomaly; codes 9 to 15 act as
// normal). Each output channel drops its fraction bits and clamps at 255.
// Throughput is one item per clock while out_stall is low. Coefficient
// select, multiply, then row sum with clamp take an item to out_valid, each
// behind its own register. Stages hold their item under stall and empty
// stages fill up, so in_stall rises only when all three stages are full and
// the output is stalled. vision_mode is sampled as the item enters the first
// stage; write cfg_data only while the pipeline is empty.
`timescale 1ns / 1ps
`default_nettype none

module color_vision_matrix_filter
  import cvmf_pkg::*;
#(
  parameter int unsigned COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration
  input  wire logic              cfg_write,
  input  wire logic [MODE_W-1:0] cfg_data,
  // pixel in
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [PIX_W-1:0]  red_in,
  input  wire logic [PIX_W-1:0]  green_in,
  input  wire logic [PIX_W-1:0]  blue_in,
  // pixel out
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [PIX_W-1:0]       red_out,
  output logic [PIX_W-1:0]       green_out,
  output logic [PIX_W-1:0]       blue_out
);

  localparam int unsigned CW = COEF_FRAC_BITS + 1;
  localparam int unsigned PW = CW + PIX_W;

  logic [MODE_W-1:0] vision_mode;

  // per-stage load enables: a stage takes new data when empty or when the
  // stage after it moves on
  logic s1_load;
  logic s2_load;
  logic s3_load;

  logic                     s1_valid;
  logic [2:0][PIX_W-1:0]    s1_px;
  logic [2:0][2:0][CW-1:0]  s1_coef;
  logic                     s2_valid;
  logic [2:0][2:0][PW-1:0]  s2_prod;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      vision_mode <= MODE_NORMAL;
    end else if (cfg_write) begin
      vision_mode <= cfg_data;
    end
  end

  // stall chain, output register is the last stage
  assign s3_load  = !out_valid || !out_stall;
  assign s2_load  = !s2_valid || s3_load;
  assign s1_load  = !s1_valid || s2_load;
  assign in_stall = !s1_load;

  // stage 1: matrix select and pixel capture
  cvmf_coef_sel #(
    .FRAC_BITS (COEF_FRAC_BITS)
  ) u_coef_sel (
    .clk      (clk),
    .rst      (rst),
    .load     (s1_load),
    .valid_in (in_valid),
    .red      (red_in),
    .green    (green_in),
    .blue     (blue_in),
    .mode     (vision_mode),
    .valid    (s1_valid),
    .px       (s1_px),
    .coef     (s1_coef)
  );

  // stage 2: nine products
  cvmf_mult #(
    .FRAC_BITS (COEF_FRAC_BITS)
  ) u_mult (
    .clk      (clk),
    .rst      (rst),
    .load     (s2_load),
    .valid_in (s1_valid),
    .px       (s1_px),
    .coef     (s1_coef),
    .valid    (s2_valid),
    .prod     (s2_prod)
  );

  // stage 3: row sums, truncate and clamp into the output register
  cvmf_sum_sat #(
    .FRAC_BITS (COEF_FRAC_BITS)
  ) u_sum_sat (
    .clk      (clk),
    .rst      (rst),
    .load     (s3_load),
    .valid_in (s2_valid),
    .prod     (s2_prod),
    .valid    (out_valid),
    .red      (red_out),
    .green    (green_out),
    .blue     (blue_out)
  );

`ifndef SYNTHESIS
  // back-pressure only when every stage holds an item
  a_stall_full : assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && s2_valid && out_valid))
    else $error("input stalled while the pipeline has a free stage");

  // a held first-stage item is neither lost nor altered
  a_s1_hold : assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s2_load) |=> (s1_valid && $stable(s1_px) && $stable(s1_coef)))
    else $error("stage 1 item changed while held");

  // a held second-stage item is neither lost nor altered
  a_s2_hold : assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !s3_load) |=> (s2_valid && $stable(s2_prod)))
    else $error("stage 2 item changed while held");
`endif

endmodule

`default_nettype wire
